FILE: hw/rtl/quaternion_to_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_assert.svh
// Assertion macros shared by the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// a implies b in the same cycle
`define Q2R_ASSERT_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a implies b after the ##n delay
`define Q2R_ASSERT_DELAY(lbl, a, n, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) else $error(msg);

`endif

FILE: hw/rtl/q2r_pkg.sv
// ----------------------------------------------------------------------------
// q2r_pkg
// Types and constants of the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package q2r_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int NUM_ENTRIES    = 9;
  localparam int SUM_W          = 33;
  localparam int ROOT_STEPS     = 17;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] col0_row0;
    logic signed [15:0] col0_row1;
    logic signed [15:0] col0_row2;
    logic signed [15:0] col1_row0;
    logic signed [15:0] col1_row1;
    logic signed [15:0] col1_row2;
    logic signed [15:0] col2_row0;
    logic signed [15:0] col2_row1;
    logic signed [15:0] col2_row2;
    logic [15:0]        magnitude;
    logic               zero_length;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]                   s;
    logic                               zero;
    logic [NUM_ENTRIES-1:0]             neg;
    logic [NUM_ENTRIES-1:0][SUM_W-1:0]  mag;
  } front_t;

endpackage

FILE: hw/rtl/q2r_front.sv
// ----------------------------------------------------------------------------
// q2r_front
// Two register stages: squares and cross products, then the sum of squares
// and the nine numerators as sign and magnitude.
// ----------------------------------------------------------------------------
module q2r_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  q2r_pkg::quat_t  quat,
  output logic            valid_out,
  output q2r_pkg::front_t fr
);
  import q2r_pkg::*;

  logic               v1;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [33:0] num [NUM_ENTRIES];
  front_t             fr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1        <= valid_in;
      valid_out <= v1;
    end
    ww <= quat.quat_w * quat.quat_w;
    xx <= quat.quat_x * quat.quat_x;
    yy <= quat.quat_y * quat.quat_y;
    zz <= quat.quat_z * quat.quat_z;
    xy <= quat.quat_x * quat.quat_y;
    wz <= quat.quat_w * quat.quat_z;
    xz <= quat.quat_x * quat.quat_z;
    wy <= quat.quat_w * quat.quat_y;
    yz <= quat.quat_y * quat.quat_z;
    wx <= quat.quat_w * quat.quat_x;
    fr <= fr_next;
  end

  always_comb begin
    num[0] = 34'(ww) + 34'(xx) - 34'(yy) - 34'(zz);
    num[1] = (34'(xy) + 34'(wz)) <<< 1;
    num[2] = (34'(xz) - 34'(wy)) <<< 1;
    num[3] = (34'(xy) - 34'(wz)) <<< 1;
    num[4] = 34'(ww) - 34'(xx) + 34'(yy) - 34'(zz);
    num[5] = (34'(yz) + 34'(wx)) <<< 1;
    num[6] = (34'(xz) + 34'(wy)) <<< 1;
    num[7] = (34'(yz) - 34'(wx)) <<< 1;
    num[8] = 34'(ww) - 34'(xx) - 34'(yy) + 34'(zz);
    fr_next.s    = SUM_W'(ww) + SUM_W'(xx) + SUM_W'(yy) + SUM_W'(zz);
    fr_next.zero = (fr_next.s == '0);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      fr_next.neg[i] = num[i][33];
      fr_next.mag[i] = num[i][33] ? SUM_W'(-num[i]) : SUM_W'(num[i]);
    end
  end

endmodule

FILE: hw/rtl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalises a Q3.12 quaternion and gives its 3x3 rotation matrix in Q1.14
// together with its length.
//
// Input: a word on quat is taken at each clock edge with start high; busy
// stays low, so a quaternion may enter in every cycle.
// Output: one word per quaternion on result, marked by strobe for one cycle.
// A word taken with start passes the front stages, the input register,
// the divider and root stages and the output register, and then appears
// with strobe. Throughput: one word per cycle.
// The length of the pipeline is set by the restoring dividers (one quotient
// bit per stage) and the square root (one result bit per stage), which run
// side by side through the same stages.
// The receiver cannot hold results off; each word is on result for one cycle.
// Reset clears all valid bits; words in flight are dropped.
// A zero quaternion gives the identity and sets zero_length.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
  parameter int COEF_FRAC_BITS = q2r_pkg::COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  q2r_pkg::quat_t    quat,
  output logic              strobe,
  output q2r_pkg::result_t  result
);
  import q2r_pkg::*;

  `include "quaternion_to_rotation_matrix_assert.svh"

  localparam int DS  = COEF_FRAC_BITS + 1;
  localparam int NST = (DS > ROOT_STEPS) ? DS : ROOT_STEPS;
  localparam int DW  = COEF_FRAC_BITS + SUM_W + 1;
  localparam int LAT = NST + 4;
  localparam logic [15:0] ONE =
    (COEF_FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << COEF_FRAC_BITS);

  logic   fvalid;
  front_t fr;

  q2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .quat      (quat),
    .valid_out (fvalid),
    .fr        (fr)
  );

  assign busy = 1'b0;

  logic                    vld  [NST+1];
  logic [SUM_W-1:0]        sv   [NST+1];
  logic                    zf   [NST+1];
  logic [NUM_ENTRIES-1:0]  ng   [NST+1];
  logic [SUM_W-1:0]        drem [NST+1][NUM_ENTRIES];
  logic [DS-1:0]           dlow [NST+1][NUM_ENTRIES];
  logic [DS-1:0]           quo  [NST+1][NUM_ENTRIES];
  logic [20:0]             srem [NST+1];
  logic [16:0]             root [NST+1];

  logic [DW-1:0] dvd [NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      dvd[i] = {1'b0, fr.mag[i], {COEF_FRAC_BITS{1'b0}}} + DW'(fr.s >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= fvalid;
    sv[0]   <= fr.s;
    zf[0]   <= fr.zero;
    ng[0]   <= fr.neg;
    srem[0] <= '0;
    root[0] <= '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      drem[0][i] <= SUM_W'(dvd[i] >> DS);
      dlow[0][i] <= dvd[i][DS-1:0];
      quo[0][i]  <= '0;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int DB = (k < DS) ? DS - 1 - k : 0;
    localparam int SB = (k < ROOT_STEPS) ? 2 * (ROOT_STEPS - 1 - k) + 1 : 1;
    logic [SUM_W:0]   trial_r [NUM_ENTRIES];
    logic [SUM_W:0]   sv_x;
    logic [20:0]      srem_t;
    logic [18:0]      strial;

    always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        trial_r[i] = {drem[k][i], dlow[k][i][DB]};
      end
      sv_x   = {1'b0, sv[k]};
      srem_t = {srem[k][18:0], sv_x[SB -: 2]};
      strial = {root[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      sv[k+1] <= sv[k];
      zf[k+1] <= zf[k];
      ng[k+1] <= ng[k];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        dlow[k+1][i] <= dlow[k][i];
        if (k < DS) begin
          if (trial_r[i] >= {1'b0, sv[k]}) begin
            drem[k+1][i] <= SUM_W'(trial_r[i] - {1'b0, sv[k]});
            quo[k+1][i]  <= {quo[k][i][DS-2:0], 1'b1};
          end else begin
            drem[k+1][i] <= trial_r[i][SUM_W-1:0];
            quo[k+1][i]  <= {quo[k][i][DS-2:0], 1'b0};
          end
        end else begin
          drem[k+1][i] <= drem[k][i];
          quo[k+1][i]  <= quo[k][i];
        end
      end
      if (k < ROOT_STEPS) begin
        if (srem_t >= 21'(strial)) begin
          srem[k+1] <= srem_t - 21'(strial);
          root[k+1] <= {root[k][15:0], 1'b1};
        end else begin
          srem[k+1] <= srem_t;
          root[k+1] <= {root[k][15:0], 1'b0};
        end
      end else begin
        srem[k+1] <= srem[k];
        root[k+1] <= root[k];
      end
    end
  end

  logic [15:0] ent [NUM_ENTRIES];
  logic [16:0] qc  [NUM_ENTRIES];
  result_t     result_next;
  logic        zero_word;

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      qc[i] = (32'(quo[NST][i]) > 32'd32768) ? 17'd32768 : 17'(quo[NST][i]);
      if (zf[NST]) begin
        ent[i] = (i == 0 || i == 4 || i == 8) ? ONE : 16'h0000;
      end else if (ng[NST][i]) begin
        ent[i] = 16'(-qc[i]);
      end else begin
        ent[i] = qc[i][15] ? 16'h7fff : qc[i][15:0];
      end
    end
    result_next.col0_row0   = ent[0];
    result_next.col0_row1   = ent[1];
    result_next.col0_row2   = ent[2];
    result_next.col1_row0   = ent[3];
    result_next.col1_row1   = ent[4];
    result_next.col1_row2   = ent[5];
    result_next.col2_row0   = ent[6];
    result_next.col2_row1   = ent[7];
    result_next.col2_row2   = ent[8];
    result_next.magnitude   = root[NST][16] ? 16'hffff : root[NST][15:0];
    result_next.zero_length = zf[NST];
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= vld[NST];
    result <= result_next;
  end

  assign zero_word = strobe && result.zero_length;

  `Q2R_ASSERT_DELAY(a_latency, start && !busy, LAT, strobe, "result word missing")
  `Q2R_ASSERT_IMPLY(a_zero_mag, zero_word, result.magnitude == 16'h0000, "magnitude not zero")
  `Q2R_ASSERT_IMPLY(a_zero_diag, zero_word, result.col1_row1 == ONE, "diagonal not one")

endmodule
